// ===== rtl/tes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

   localparam int CAPACITY   = 16;
   localparam int TYPE_COUNT = 32;

   localparam int CAP_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int TIME_W = 64;
   localparam int TYPE_W = 5;
   localparam int CYC_W  = 32;
   localparam int OP_W   = 3;

   localparam logic [OP_W-1:0] OP_SCHED_REL = 3'd0;
   localparam logic [OP_W-1:0] OP_SCHED_ABS = 3'd1;
   localparam logic [OP_W-1:0] OP_DESCHED   = 3'd2;
   localparam logic [OP_W-1:0] OP_RESCHED   = 3'd3;
   localparam logic [OP_W-1:0] OP_ADVANCE   = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0] trig_time;
      logic [TYPE_W-1:0] kind;
      logic              notify;
   } entry_type;

   typedef struct packed {
      logic kind_hit;
      logic due;
      logic better;
   } pick_type;

endpackage

`default_nettype wire

// ===== rtl/timed_event_scheduler_top.sv =====
// The type search of deschedule, reschedule and schedule (unless duplicates are allowed)
// reads one entry a cycle from the event store, which has separate read and write ports.
// An advance with nothing due makes one scan of the pending events; each fired event adds
// a new scan plus a shift of the entries above it.
// One operation is in flight at a time; a finished beat may wait in the output register.
// Reset clears the pending count, the current time and the output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module timed_event_scheduler_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tes_pkg::OP_W-1:0]         req_op,
   input  logic [tes_pkg::TYPE_W-1:0]       req_event_type,
   input  logic [tes_pkg::CYC_W-1:0]        req_cycles,
   input  logic [tes_pkg::TIME_W-1:0]       req_abs_time,
   input  logic                             req_allow_duplicate,
   input  logic                             req_notify,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_ok,
   output logic                             rsp_fired,
   output logic [tes_pkg::TYPE_W-1:0]       rsp_fired_type,
   output logic [tes_pkg::TIME_W-1:0]       rsp_fired_time,
   output logic                             rsp_fired_notify,
   output logic [tes_pkg::TIME_W-1:0]       rsp_now_time,
   output logic                             rsp_last
);
   import tes_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_FIND   = 8'b0000_0010,
      ST_INSERT = 8'b0000_0100,
      ST_WRITE  = 8'b0000_1000,
      ST_SELECT = 8'b0001_0000,
      ST_EMIT   = 8'b0010_0000,
      ST_SHIFT  = 8'b0100_0000,
      ST_STATUS = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [CAP_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               have_ff, have_in;
   logic               ok_ff, ok_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [OP_W-1:0]    op_ff, op_in;
   logic [TYPE_W-1:0]  kind_ff, kind_in;
   logic               notify_ff, notify_in;
   logic [TIME_W-1:0]  tgt_ff, tgt_in;
   entry_type          best_ff, best_in;
   logic [CAP_W-1:0]   best_idx_ff, best_idx_in;
   logic [CAP_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               hit_notify_ff, hit_notify_in;

   logic               rsp_ok_ff, rsp_ok_in;
   logic               rsp_fired_ff, rsp_fired_in;
   logic [TYPE_W-1:0]  rsp_fired_type_ff, rsp_fired_type_in;
   logic [TIME_W-1:0]  rsp_fired_time_ff, rsp_fired_time_in;
   logic               rsp_fired_notify_ff, rsp_fired_notify_in;
   logic [TIME_W-1:0]  rsp_now_time_ff, rsp_now_time_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_load;
   logic               rsp_free;

   entry_type          mem [CAPACITY];
   entry_type          rd_data_ff;
   logic               mem_we;
   logic [CAP_W-1:0]   mem_waddr;
   entry_type          mem_wdata;

   logic               issue;
   logic               kind_ok;
   logic [TIME_W-1:0]  sum_time;
   pick_type           pick;

   tes_pick u_pick (
      .entry    (rd_data_ff),
      .best     (best_ff),
      .have     (have_ff),
      .now_time (now_ff),
      .kind     (kind_ff),
      .pick     (pick)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign issue    = (scan_ff < count_ff);
   assign kind_ok  = (int'(req_event_type) < TYPE_COUNT);
   assign sum_time = now_ff + {{(TIME_W-CYC_W){1'b0}}, req_cycles};

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_fired_type   = rsp_fired_type_ff;
   assign rsp_fired_time   = rsp_fired_time_ff;
   assign rsp_fired_notify = rsp_fired_notify_ff;
   assign rsp_now_time     = rsp_now_time_ff;
   assign rsp_last         = rsp_last_ff;

   always_comb begin
      state_in            = state_ff;
      count_in            = count_ff;
      now_in              = now_ff;
      scan_in             = scan_ff;
      rd_valid_in         = 1'b0;
      rd_idx_in           = rd_idx_ff;
      have_in             = have_ff;
      ok_in               = ok_ff;
      op_in               = op_ff;
      kind_in             = kind_ff;
      notify_in           = notify_ff;
      tgt_in              = tgt_ff;
      best_in             = best_ff;
      best_idx_in         = best_idx_ff;
      hit_idx_in          = hit_idx_ff;
      hit_notify_in       = hit_notify_ff;
      mem_we              = 1'b0;
      mem_waddr           = rd_idx_ff - CAP_W'(1);
      mem_wdata           = rd_data_ff;
      rsp_load            = 1'b0;
      rsp_ok_in           = ok_ff;
      rsp_fired_in        = 1'b0;
      rsp_fired_type_in   = '0;
      rsp_fired_time_in   = '0;
      rsp_fired_notify_in = 1'b0;
      rsp_now_time_in     = now_ff;
      rsp_last_in         = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               kind_in   = req_event_type;
               notify_in = req_notify;
               tgt_in    = (req_op == OP_SCHED_ABS) ? req_abs_time : sum_time;
               scan_in   = '0;
               have_in   = 1'b0;
               ok_in     = 1'b0;
               unique case (req_op) inside
                  OP_SCHED_REL, OP_SCHED_ABS: begin
                     if (!kind_ok) begin
                        state_in = ST_STATUS;
                     end else if (req_allow_duplicate) begin
                        state_in = ST_INSERT;
                     end else begin
                        state_in = ST_FIND;
                     end
                  end
                  OP_DESCHED, OP_RESCHED: begin
                     state_in = kind_ok ? ST_FIND : ST_STATUS;
                  end
                  OP_ADVANCE: begin
                     now_in   = sum_time;
                     state_in = ST_SELECT;
                  end
                  default: begin
                     state_in = ST_STATUS;
                  end
               endcase
            end
         end
         ST_FIND: begin
            if (rd_valid_ff && pick.kind_hit) begin
               hit_idx_in    = rd_idx_ff;
               hit_notify_in = rd_data_ff.notify;
               unique case (op_ff) inside
                  OP_DESCHED: begin
                     scan_in  = CNT_W'(rd_idx_ff) + CNT_W'(1);
                     state_in = ST_SHIFT;
                  end
                  OP_RESCHED: begin
                     state_in = ST_WRITE;
                  end
                  default: begin
                     state_in = ST_STATUS;
                  end
               endcase
            end else if (!rd_valid_ff && !issue) begin
               if ((op_ff == OP_SCHED_REL) || (op_ff == OP_SCHED_ABS)) begin
                  state_in = ST_INSERT;
               end else begin
                  state_in = ST_STATUS;
               end
            end else begin
               rd_valid_in = issue;
               rd_idx_in   = scan_ff[CAP_W-1:0];
               if (issue) begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end
         ST_INSERT: begin
            if (count_ff < CNT_W'(CAPACITY)) begin
               mem_we    = 1'b1;
               mem_waddr = count_ff[CAP_W-1:0];
               mem_wdata = '{trig_time: tgt_ff, kind: kind_ff, notify: notify_ff};
               count_in  = count_ff + CNT_W'(1);
               ok_in     = 1'b1;
            end
            state_in = ST_STATUS;
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx_ff;
            mem_wdata = '{trig_time: tgt_ff, kind: kind_ff, notify: hit_notify_ff};
            ok_in     = 1'b1;
            state_in  = ST_STATUS;
         end
         ST_SELECT: begin
            if (rd_valid_ff && pick.due && pick.better) begin
               best_in     = rd_data_ff;
               best_idx_in = rd_idx_ff;
               have_in     = 1'b1;
            end
            if (!rd_valid_ff && !issue) begin
               ok_in    = 1'b1;
               state_in = have_ff ? ST_EMIT : ST_STATUS;
            end else begin
               rd_valid_in = issue;
               rd_idx_in   = scan_ff[CAP_W-1:0];
               if (issue) begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load            = 1'b1;
               rsp_ok_in           = 1'b1;
               rsp_fired_in        = 1'b1;
               rsp_fired_type_in   = best_ff.kind;
               rsp_fired_time_in   = best_ff.trig_time;
               rsp_fired_notify_in = best_ff.notify;
               rsp_last_in         = 1'b0;
               scan_in             = CNT_W'(best_idx_ff) + CNT_W'(1);
               state_in            = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // Entries above the removed one move down by one place.
            if (rd_valid_ff) begin
               mem_we = 1'b1;
            end
            if (!rd_valid_ff && !issue) begin
               count_in = count_ff - CNT_W'(1);
               if (op_ff == OP_ADVANCE) begin
                  scan_in  = '0;
                  have_in  = 1'b0;
                  state_in = ST_SELECT;
               end else begin
                  ok_in    = 1'b1;
                  state_in = ST_STATUS;
               end
            end else begin
               rd_valid_in = issue;
               rd_idx_in   = scan_ff[CAP_W-1:0];
               if (issue) begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end
         ST_STATUS: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         have_ff      <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         scan_ff      <= scan_in;
         rd_valid_ff  <= rd_valid_in;
         have_ff      <= have_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      op_ff         <= op_in;
      kind_ff       <= kind_in;
      notify_ff     <= notify_in;
      tgt_ff        <= tgt_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_notify_ff <= hit_notify_in;
      if (rsp_load) begin
         rsp_ok_ff           <= rsp_ok_in;
         rsp_fired_ff        <= rsp_fired_in;
         rsp_fired_type_ff   <= rsp_fired_type_in;
         rsp_fired_time_ff   <= rsp_fired_time_in;
         rsp_fired_notify_ff <= rsp_fired_notify_in;
         rsp_now_time_ff     <= rsp_now_time_in;
         rsp_last_ff         <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_ff[CAP_W-1:0]];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("pending count exceeds capacity");

   a_fired_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != ST_IDLE))
      else $error("fired beat pending while idle");

   a_fired_due: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fired_ff) |-> (rsp_fired_time_ff <= now_ff))
      else $error("fired event is not due");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_valid_ff && !mem_we))
      else $error("store activity while idle");

endmodule

`default_nettype wire

// ===== rtl/tes_pick.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tes_pick (
   input  tes_pkg::entry_type              entry,
   input  tes_pkg::entry_type              best,
   input  logic                            have,
   input  logic [tes_pkg::TIME_W-1:0]      now_time,
   input  logic [tes_pkg::TYPE_W-1:0]      kind,
   output tes_pkg::pick_type               pick
);
   import tes_pkg::*;

   // An entry beats the current best on an earlier time, or on an equal time
   // with a lower type. Equal entries keep the older one, since the scan runs
   // from the oldest entry upward.
   always_comb begin
      pick.kind_hit = (entry.kind == kind);
      pick.due      = (entry.trig_time <= now_time);
      pick.better   = !have
                      || (entry.trig_time < best.trig_time)
                      || ((entry.trig_time == best.trig_time) && (entry.kind < best.kind));
   end

endmodule

`default_nettype wire
